### rtl/x86e_pkg.sv
// Shared types, form codes and opcode constants of the x86-64 instruction byte encoder.
package x86e_pkg;

   localparam int MaxBytes  = 13;
   localparam int HeadBytes = 6;
   localparam int TailBytes = 3;
   localparam int LenWidth  = $clog2(MaxBytes + 1);

   typedef enum logic [4:0] {
      CMD_CALL_REG  = 5'd0,
      CMD_MOV16IMM  = 5'd1,
      CMD_MOV32IMM  = 5'd2,
      CMD_SAL       = 5'd3,
      CMD_XOR       = 5'd4,
      CMD_OR        = 5'd5,
      CMD_RET       = 5'd6,
      CMD_MOV64IMM  = 5'd7,
      CMD_CALL_REL  = 5'd8,
      CMD_MOVL_IMEM = 5'd9,
      CMD_MOVL_RMEM = 5'd10,
      CMD_MOVQ_RR   = 5'd11,
      CMD_MOVL_LOAD = 5'd12,
      CMD_ADD_EAX   = 5'd13,
      CMD_MOVL_RR   = 5'd14,
      CMD_PUSH      = 5'd15,
      CMD_POP       = 5'd16,
      CMD_AND_RAX   = 5'd17,
      CMD_CMP_IMM32 = 5'd18,
      CMD_XOR_RAX   = 5'd19,
      CMD_NOT       = 5'd20,
      CMD_MOVSX     = 5'd21,
      CMD_CMPL_IMM8 = 5'd22,
      CMD_JZ        = 5'd23,
      CMD_CALL_PTR  = 5'd24
   } cmd_type;

   localparam logic [7:0] OP_REX_BASE = 8'h40;
   localparam logic [7:0] OP_REX_W    = 8'h48;
   localparam logic [7:0] OP_REX_B    = 8'h41;
   localparam logic [7:0] OP_REX_WB   = 8'h49;
   localparam logic [7:0] OP_OPSIZE   = 8'h66;
   localparam logic [7:0] OP_GRP5     = 8'hff;
   localparam logic [7:0] OP_MOV_IMM  = 8'hc7;
   localparam logic [7:0] OP_SHIFT_I8 = 8'hc1;
   localparam logic [7:0] OP_XOR_RM   = 8'h33;
   localparam logic [7:0] OP_OR_RM    = 8'h09;
   localparam logic [7:0] OP_RET      = 8'hc3;
   localparam logic [7:0] OP_MOV_RI   = 8'hb8;
   localparam logic [7:0] OP_CALL_REL = 8'he8;
   localparam logic [7:0] OP_MOV_ST   = 8'h89;
   localparam logic [7:0] OP_MOV_LD   = 8'h8b;
   localparam logic [7:0] OP_ADD_EAX  = 8'h05;
   localparam logic [7:0] OP_PUSH     = 8'h50;
   localparam logic [7:0] OP_POP      = 8'h58;
   localparam logic [7:0] OP_AND_RAX  = 8'h25;
   localparam logic [7:0] OP_GRP1_I32 = 8'h81;
   localparam logic [7:0] OP_XOR_RAX  = 8'h35;
   localparam logic [7:0] OP_GRP3     = 8'hf7;
   localparam logic [7:0] OP_ESCAPE   = 8'h0f;
   localparam logic [7:0] OP_MOVSX16  = 8'hbf;
   localparam logic [7:0] OP_GRP1_I8  = 8'h83;
   localparam logic [7:0] OP_JZ       = 8'h74;
   localparam logic [7:0] OP_SIB_RSP  = 8'h24;
   localparam logic [7:0] OP_CALL_R10 = 8'hd2;

   localparam logic [3:0] REG_R10 = 4'd10;

   localparam logic [1:0] MOD_INDIRECT = 2'd0;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_REGISTER = 2'd3;

   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [LenWidth-1:0]      len;
      logic                     err;
      logic                     drop;
   } enc_result_type;

endpackage

### rtl/x86e_encoder.sv
// Combinational encoder: one registered request to the byte list of its instruction.
module x86e_encoder (
   input  logic [4:0]               cmd,
   input  logic [3:0]               reg_a,
   input  logic [3:0]               reg_b,
   input  logic [63:0]              imm,
   input  logic [63:0]              code_base,
   input  logic [31:0]              emitted_count,
   output x86e_pkg::enc_result_type result
);
   import x86e_pkg::*;

   logic                        use_mr;
   logic                        pre66;
   logic [3:0]                  rex_base;
   logic [7:0]                  op1;
   logic                        two;
   logic [7:0]                  op2;
   logic [1:0]                  md;
   logic [3:0]                  rg;
   logic [3:0]                  rmv;
   logic [3:0]                  imm_n;
   logic [2:0]                  raw_n;
   logic [7:0]                  raw0;
   logic [7:0]                  raw1;
   logic                        has_tail;
   logic                        err;
   logic                        drop;
   logic [63:0]                 src;
   logic [63:0]                 here;
   logic [63:0]                 disp;
   logic                        disp_ok;
   logic [3:0]                  rex;
   logic                        use_sib;
   logic                        zero_disp;
   logic [HeadBytes-1:0][7:0]   head;
   logic [2:0]                  hn;
   logic [TailBytes-1:0][7:0]   tail;
   logic [3:0]                  imm_end;
   logic [3:0]                  kk;
   logic [3:0]                  ioff;
   logic [3:0]                  toff;
   logic [MaxBytes-1:0][7:0]    bytes;

   assign here    = code_base + {32'd0, emitted_count};
   assign disp    = imm - here - 64'd5;
   assign disp_ok = (disp[63:31] == '0) || (&disp[63:31]);
   assign tail    = {OP_CALL_R10, OP_GRP5, OP_REX_B};

   always_comb begin
      use_mr   = 1'b1;
      pre66    = 1'b0;
      rex_base = 4'd0;
      op1      = OP_GRP5;
      two      = 1'b0;
      op2      = OP_MOVSX16;
      md       = MOD_REGISTER;
      rg       = 4'd0;
      rmv      = reg_a;
      imm_n    = 4'd0;
      raw_n    = 3'd0;
      raw0     = OP_RET;
      raw1     = 8'h00;
      has_tail = 1'b0;
      err      = 1'b0;
      drop     = 1'b0;
      src      = imm;
      unique case (cmd_type'(cmd))
         CMD_CALL_REG: begin
            rg = 4'd2;
         end
         CMD_MOV16IMM: begin
            pre66 = 1'b1;
            op1   = OP_MOV_IMM;
            imm_n = 4'd2;
         end
         CMD_MOV32IMM: begin
            op1   = OP_MOV_IMM;
            imm_n = 4'd4;
         end
         CMD_SAL: begin
            rex_base = 4'd8;
            op1      = OP_SHIFT_I8;
            rg       = 4'd4;
            imm_n    = 4'd1;
         end
         CMD_XOR: begin
            rex_base = 4'd8;
            op1      = OP_XOR_RM;
            rg       = reg_b;
         end
         CMD_OR: begin
            rex_base = 4'd8;
            op1      = OP_OR_RM;
            rg       = reg_b;
         end
         CMD_RET: begin
            use_mr = 1'b0;
            raw_n  = 3'd1;
            raw0   = OP_RET;
         end
         CMD_MOV64IMM: begin
            use_mr = 1'b0;
            raw_n  = 3'd2;
            raw0   = reg_a[3] ? OP_REX_WB : OP_REX_W;
            raw1   = OP_MOV_RI | {5'd0, reg_a[2:0]};
            imm_n  = 4'd8;
         end
         CMD_CALL_REL: begin
            use_mr = 1'b0;
            src    = disp;
            if (disp_ok) begin
               raw_n = 3'd1;
               raw0  = OP_CALL_REL;
               imm_n = 4'd4;
            end else begin
               err = 1'b1;
            end
         end
         CMD_MOVL_IMEM: begin
            op1   = OP_MOV_IMM;
            md    = MOD_INDIRECT;
            imm_n = 4'd4;
         end
         CMD_MOVL_RMEM: begin
            op1 = OP_MOV_ST;
            md  = MOD_INDIRECT;
            rg  = reg_a;
            rmv = reg_b;
         end
         CMD_MOVQ_RR: begin
            rex_base = 4'd8;
            op1      = OP_MOV_ST;
            rg       = reg_a;
            rmv      = reg_b;
         end
         CMD_MOVL_LOAD: begin
            op1 = OP_MOV_LD;
            md  = MOD_INDIRECT;
            rg  = reg_b;
         end
         CMD_ADD_EAX: begin
            use_mr = 1'b0;
            raw_n  = 3'd1;
            raw0   = OP_ADD_EAX;
            imm_n  = 4'd4;
         end
         CMD_MOVL_RR: begin
            op1 = OP_MOV_ST;
            rg  = reg_a;
            rmv = reg_b;
         end
         CMD_PUSH, CMD_POP: begin
            use_mr = 1'b0;
            if (reg_a[3]) begin
               raw_n = 3'd2;
               raw0  = OP_REX_B;
               raw1  = (cmd_type'(cmd) == CMD_PUSH ? OP_PUSH : OP_POP)
                       | {5'd0, reg_a[2:0]};
            end else begin
               raw_n = 3'd1;
               raw0  = (cmd_type'(cmd) == CMD_PUSH ? OP_PUSH : OP_POP)
                       | {5'd0, reg_a[2:0]};
            end
         end
         CMD_AND_RAX: begin
            use_mr = 1'b0;
            raw_n  = 3'd2;
            raw0   = OP_REX_W;
            raw1   = OP_AND_RAX;
            imm_n  = 4'd4;
         end
         CMD_CMP_IMM32: begin
            rex_base = 4'd8;
            op1      = OP_GRP1_I32;
            rg       = 4'd7;
            imm_n    = 4'd4;
         end
         CMD_XOR_RAX: begin
            use_mr = 1'b0;
            raw_n  = 3'd2;
            raw0   = OP_REX_W;
            raw1   = OP_XOR_RAX;
            imm_n  = 4'd4;
         end
         CMD_NOT: begin
            rex_base = 4'd8;
            op1      = OP_GRP3;
            rg       = 4'd2;
         end
         CMD_MOVSX: begin
            op1 = OP_ESCAPE;
            two = 1'b1;
            md  = MOD_INDIRECT;
            rg  = reg_b;
         end
         CMD_CMPL_IMM8: begin
            op1   = OP_GRP1_I8;
            rg    = 4'd7;
            imm_n = 4'd1;
         end
         CMD_JZ: begin
            use_mr = 1'b0;
            raw_n  = 3'd1;
            raw0   = OP_JZ;
            imm_n  = 4'd1;
         end
         CMD_CALL_PTR: begin
            // Load the target into r10, then call through it.
            use_mr   = 1'b0;
            raw_n    = 3'd2;
            raw0     = OP_REX_WB;
            raw1     = OP_MOV_RI | {5'd0, REG_R10[2:0]};
            imm_n    = 4'd8;
            has_tail = 1'b1;
         end
         default: begin
            use_mr = 1'b0;
            drop   = 1'b1;
         end
      endcase
   end

   assign rex       = rex_base | {1'b0, rg[3], 1'b0, rmv[3]};
   assign use_sib   = (rmv[2:0] == 3'd4) && (md != MOD_REGISTER);
   assign zero_disp = (rmv[2:0] == 3'd5) && (md == MOD_INDIRECT);

   always_comb begin
      head = '0;
      hn   = 3'd0;
      if (use_mr) begin
         if (pre66) begin
            head[hn] = OP_OPSIZE;
            hn       = hn + 3'd1;
         end
         if (rex != 4'd0) begin
            head[hn] = OP_REX_BASE | {4'd0, rex};
            hn       = hn + 3'd1;
         end
         head[hn] = op1;
         hn       = hn + 3'd1;
         if (two) begin
            head[hn] = op2;
            hn       = hn + 3'd1;
         end
         // A base of rbp or r13 with no displacement must be coded as a zero disp8.
         if (zero_disp) begin
            head[hn] = {MOD_DISP8, rg[2:0], rmv[2:0]};
            hn       = hn + 3'd1;
            head[hn] = 8'h00;
            hn       = hn + 3'd1;
         end else begin
            head[hn] = {md, rg[2:0], rmv[2:0]};
            hn       = hn + 3'd1;
            if (use_sib) begin
               head[hn] = OP_SIB_RSP;
               hn       = hn + 3'd1;
            end
         end
      end else begin
         head[0] = raw0;
         head[1] = raw1;
         hn      = raw_n;
      end
   end

   assign imm_end = {1'b0, hn} + imm_n;

   always_comb begin
      bytes = '0;
      kk    = 4'd0;
      ioff  = 4'd0;
      toff  = 4'd0;
      for (int k = 0; k < MaxBytes; k++) begin
         kk   = 4'(k);
         ioff = kk - {1'b0, hn};
         toff = kk - imm_end;
         if (kk < {1'b0, hn}) begin
            bytes[k] = head[kk[2:0]];
         end else if (kk < imm_end) begin
            bytes[k] = src[{ioff[2:0], 3'b000} +: 8];
         end else if (toff < 4'(TailBytes)) begin
            bytes[k] = tail[toff[1:0]];
         end
      end
   end

   always_comb begin
      result.bytes = err ? '0 : bytes;
      result.len   = (err || drop) ? '0
                   : imm_end + (has_tail ? 4'(TailBytes) : 4'd0);
      result.err   = err;
      result.drop  = drop;
   end

endmodule

### rtl/x86e_serializer.sv
// Output shift buffer that hands out an instruction's bytes one per response.
module x86e_serializer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  x86e_pkg::enc_result_type result,
   output logic                     free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_code_byte,
   output logic                     rsp_last_byte,
   output logic                     rsp_range_error
);
   import x86e_pkg::*;

   logic                     valid_ff, valid_in;
   logic [LenWidth-1:0]      remain_ff, remain_in;
   logic                     err_ff, err_in;
   logic [MaxBytes-1:0][7:0] buf_ff, buf_in;
   logic                     take;

   assign take = valid_ff && rsp_ready;
   assign free = !valid_ff || (take && remain_ff == LenWidth'(1));

   always_comb begin
      valid_in  = valid_ff;
      remain_in = remain_ff;
      err_in    = err_ff;
      buf_in    = buf_ff;
      priority if (load) begin
         valid_in  = 1'b1;
         remain_in = result.err ? LenWidth'(1) : result.len;
         err_in    = result.err;
         buf_in    = result.bytes;
      end else if (take) begin
         valid_in  = (remain_ff != LenWidth'(1));
         remain_in = remain_ff - LenWidth'(1);
         buf_in    = {8'h00, buf_ff[MaxBytes-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      remain_ff <= remain_in;
      err_ff    <= err_in;
      buf_ff    <= buf_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_byte   = buf_ff[0];
   assign rsp_last_byte   = (remain_ff == LenWidth'(1));
   assign rsp_range_error = err_ff;

endmodule

### rtl/x86_64_instruction_byte_encoder.sv
// Top level of the x86-64 instruction byte encoder: request register, address state, output.
// A request accepted into the request register is encoded from there and loaded into the
// output buffer once that buffer is free; its first byte is then offered from that buffer.
// Throughput: one byte per cycle while rsp_ready is high; an instruction of n bytes (1 to 13)
// goes out as n responses on the single-byte response channel.
// A new request is taken while the previous instruction's bytes are still going out.
// Reset clears the byte count, code_base and all valid flags.
module x86_64_instruction_byte_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_cmd,
   input  logic [3:0]  req_reg_a,
   input  logic [3:0]  req_reg_b,
   input  logic [63:0] req_imm,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_code_byte,
   output logic        rsp_last_byte,
   output logic        rsp_range_error
);
   import x86e_pkg::*;

   logic           s1_valid_ff, s1_valid_in;
   logic [4:0]     cmd_ff;
   logic [3:0]     reg_a_ff;
   logic [3:0]     reg_b_ff;
   logic [63:0]    imm_ff;
   logic [63:0]    base_ff;
   logic [31:0]    count_ff, count_in;
   logic           s1_move;
   logic           ser_free;
   logic           ser_load;
   logic           req_take;
   enc_result_type result;

   x86e_encoder u_encoder (
      .cmd           (cmd_ff),
      .reg_a         (reg_a_ff),
      .reg_b         (reg_b_ff),
      .imm           (imm_ff),
      .code_base     (base_ff),
      .emitted_count (count_ff),
      .result        (result)
   );

   x86e_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .load            (ser_load),
      .result          (result),
      .free            (ser_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_byte   (rsp_code_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_range_error (rsp_range_error)
   );

   // An unused form leaves the request register without occupying the output.
   assign s1_move   = s1_valid_ff && (result.drop || ser_free);
   assign ser_load  = s1_move && !result.drop;
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_move);
   assign count_in    = s1_move ? count_ff + {{(32 - LenWidth){1'b0}}, result.len} : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff    <= '0;
         base_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         count_ff    <= count_in;
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
      end
      if (req_take) begin
         cmd_ff   <= req_cmd;
         reg_a_ff <= req_reg_a;
         reg_b_ff <= req_reg_b;
         imm_ff   <= req_imm;
      end
   end

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_last_byte && rsp_code_byte == 8'h00)
      else $error("range error response is not a single zero byte");

   a_error_no_count: assert property (@(posedge clock) disable iff (reset)
      s1_move && result.err |=> count_ff == $past(count_ff))
      else $error("byte count moved on a rejected call");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

### test/x86_64_instruction_byte_encoder_check.sv
// Checker for the x86-64 instruction byte encoder: predicts each code byte and compares responses.
`timescale 1ns / 1ps
module x86_64_instruction_byte_encoder_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [4:0]  req_cmd,
   input  logic [3:0]  req_reg_a,
   input  logic [3:0]  req_reg_b,
   input  logic [63:0] req_imm,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_code_byte,
   input  logic        rsp_last_byte,
   input  logic        rsp_range_error,
   output int          failures,
   output int          bytes_outstanding,
   output int          bytes_checked,
   output int          range_errors
);
   import x86e_pkg::*;

   // ModRM reg-field opcode extensions and REX bits.
   localparam logic [3:0] EXT_MOV   = 4'd0;
   localparam logic [3:0] EXT_CALL  = 4'd2;
   localparam logic [3:0] EXT_NOT   = 4'd2;
   localparam logic [3:0] EXT_SAL   = 4'd4;
   localparam logic [3:0] EXT_CMP   = 4'd7;
   localparam logic [7:0] REX_NONE  = 8'h00;
   localparam logic [7:0] REX_R_BIT = 8'h04;
   localparam logic [7:0] REX_B_BIT = 8'h01;
   localparam logic [7:0] NO_OP2    = 8'h00;
   localparam logic [7:0] ZERO_DISP = 8'h00;
   localparam logic [63:0] CALL_LEN = 64'd5;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       err;
   } code_byte_type;

   code_byte_type expected_bytes[$];
   logic [7:0]    insn_bytes[$];
   logic [63:0]   code_base;
   logic [31:0]   emitted_count;

   initial begin
      failures = 0;
      bytes_outstanding = 0;
      bytes_checked = 0;
      range_errors = 0;
      code_base = '0;
      emitted_count = '0;
   end

   task automatic put_byte(input logic [7:0] b);
      insn_bytes.push_back(b);
   endtask

   task automatic put_le(input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++) put_byte(v[8*i +: 8]);
   endtask

   task automatic put_modrm(input logic [7:0] rex, input logic [7:0] op1, input bit two,
                            input logic [7:0] op2, input logic [1:0] md,
                            input logic [3:0] reg_f, input logic [3:0] rm_f);
      logic [7:0] prefix;
      prefix = rex;
      if (reg_f[3]) prefix = prefix | REX_R_BIT;
      if (rm_f[3]) prefix = prefix | REX_B_BIT;
      if (prefix != REX_NONE) put_byte(prefix | OP_REX_BASE);
      put_byte(op1);
      if (two) put_byte(op2);
      // Memory through rbp/r13 with no displacement needs an explicit zero disp8.
      if (rm_f[2:0] == 3'd5 && md == MOD_INDIRECT) begin
         put_byte({MOD_DISP8, reg_f[2:0], rm_f[2:0]});
         put_byte(ZERO_DISP);
      end else begin
         put_byte({md, reg_f[2:0], rm_f[2:0]});
         if (rm_f[2:0] == 3'd4 && md != MOD_REGISTER) put_byte(OP_SIB_RSP);
      end
   endtask

   task automatic put_call_reg(input logic [3:0] r);
      if (r[3]) put_byte(OP_REX_B);
      put_modrm(REX_NONE, OP_GRP5, 1'b0, NO_OP2, MOD_REGISTER, EXT_CALL, {1'b0, r[2:0]});
   endtask

   task automatic put_mov64(input logic [63:0] v, input logic [3:0] r);
      put_byte(r[3] ? OP_REX_WB : OP_REX_W);
      put_byte(OP_MOV_RI | {5'd0, r[2:0]});
      put_le(v, 8);
   endtask

   task automatic put_push_pop(input logic [7:0] base, input logic [3:0] r);
      if (r[3]) put_byte(OP_REX_B);
      put_byte(base | {5'd0, r[2:0]});
   endtask

   task automatic encode_request(input logic [4:0] cmd, input logic [3:0] ra,
                                 input logic [3:0] rb, input logic [63:0] imm);
      logic [63:0]   disp;
      bit            out_of_range;
      code_byte_type entry;
      out_of_range = 0;
      insn_bytes.delete();
      case (cmd)
         CMD_CALL_REG: put_call_reg(ra);
         CMD_MOV16IMM: begin
            put_byte(OP_OPSIZE);
            put_modrm(REX_NONE, OP_MOV_IMM, 1'b0, NO_OP2, MOD_REGISTER, EXT_MOV, ra);
            put_le(imm, 2);
         end
         CMD_MOV32IMM: begin
            put_modrm(REX_NONE, OP_MOV_IMM, 1'b0, NO_OP2, MOD_REGISTER, EXT_MOV, ra);
            put_le(imm, 4);
         end
         CMD_SAL: begin
            put_modrm(OP_REX_W, OP_SHIFT_I8, 1'b0, NO_OP2, MOD_REGISTER, EXT_SAL, ra);
            put_le(imm, 1);
         end
         CMD_XOR: put_modrm(OP_REX_W, OP_XOR_RM, 1'b0, NO_OP2, MOD_REGISTER, rb, ra);
         CMD_OR: put_modrm(OP_REX_W, OP_OR_RM, 1'b0, NO_OP2, MOD_REGISTER, rb, ra);
         CMD_RET: put_byte(OP_RET);
         CMD_MOV64IMM: put_mov64(imm, ra);
         CMD_CALL_REL: begin
            // rel32 counts from the end of the five-byte call.
            disp = imm - (code_base + {32'd0, emitted_count} + CALL_LEN);
            if (disp + 64'h0000_0000_8000_0000 > 64'h0000_0000_ffff_ffff) begin
               out_of_range = 1;
            end else begin
               put_byte(OP_CALL_REL);
               put_le(disp, 4);
            end
         end
         CMD_MOVL_IMEM: begin
            put_modrm(REX_NONE, OP_MOV_IMM, 1'b0, NO_OP2, MOD_INDIRECT, EXT_MOV, ra);
            put_le(imm, 4);
         end
         CMD_MOVL_RMEM: put_modrm(REX_NONE, OP_MOV_ST, 1'b0, NO_OP2, MOD_INDIRECT, ra, rb);
         CMD_MOVQ_RR: put_modrm(OP_REX_W, OP_MOV_ST, 1'b0, NO_OP2, MOD_REGISTER, ra, rb);
         CMD_MOVL_LOAD: put_modrm(REX_NONE, OP_MOV_LD, 1'b0, NO_OP2, MOD_INDIRECT, rb, ra);
         CMD_ADD_EAX: begin
            put_byte(OP_ADD_EAX);
            put_le(imm, 4);
         end
         CMD_MOVL_RR: put_modrm(REX_NONE, OP_MOV_ST, 1'b0, NO_OP2, MOD_REGISTER, ra, rb);
         CMD_PUSH: put_push_pop(OP_PUSH, ra);
         CMD_POP: put_push_pop(OP_POP, ra);
         CMD_AND_RAX: begin
            put_byte(OP_REX_W);
            put_byte(OP_AND_RAX);
            put_le(imm, 4);
         end
         CMD_CMP_IMM32: begin
            put_modrm(OP_REX_W, OP_GRP1_I32, 1'b0, NO_OP2, MOD_REGISTER, EXT_CMP, ra);
            put_le(imm, 4);
         end
         CMD_XOR_RAX: begin
            put_byte(OP_REX_W);
            put_byte(OP_XOR_RAX);
            put_le(imm, 4);
         end
         CMD_NOT: put_modrm(OP_REX_W, OP_GRP3, 1'b0, NO_OP2, MOD_REGISTER, EXT_NOT, ra);
         CMD_MOVSX: put_modrm(REX_NONE, OP_ESCAPE, 1'b1, OP_MOVSX16, MOD_INDIRECT, rb, ra);
         CMD_CMPL_IMM8: begin
            put_modrm(REX_NONE, OP_GRP1_I8, 1'b0, NO_OP2, MOD_REGISTER, EXT_CMP, ra);
            put_le(imm, 1);
         end
         CMD_JZ: begin
            put_byte(OP_JZ);
            put_le(imm, 1);
         end
         CMD_CALL_PTR: begin
            put_mov64(imm, REG_R10);
            put_call_reg(REG_R10);
         end
         default: ;
      endcase
      if (out_of_range) begin
         entry.code = 8'h00;
         entry.last = 1'b1;
         entry.err = 1'b1;
         expected_bytes.push_back(entry);
      end else begin
         foreach (insn_bytes[k]) begin
            entry.code = insn_bytes[k];
            entry.last = (k == insn_bytes.size() - 1);
            entry.err = 1'b0;
            expected_bytes.push_back(entry);
         end
         emitted_count = emitted_count + 32'(insn_bytes.size());
      end
   endtask

   always @(posedge clock) begin
      code_byte_type want;
      if (reset) begin
         code_base = '0;
         emitted_count = '0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%t: unexpected byte %h last %b err %b with nothing pending",
                           $realtime, rsp_code_byte, rsp_last_byte, rsp_range_error);
            end else begin
               want = expected_bytes.pop_front();
               if (want.err) range_errors++;
               if (rsp_code_byte !== want.code || rsp_last_byte !== want.last ||
                   rsp_range_error !== want.err) begin
                  failures++;
                  if (failures <= 10)
                     $display("%t: expected byte %h last %b err %b, got byte %h last %b err %b",
                              $realtime, want.code, want.last, want.err,
                              rsp_code_byte, rsp_last_byte, rsp_range_error);
               end
            end
         end
         if (csr_wr_en) code_base = csr_wr_data;
         if (req_valid && req_ready) encode_request(req_cmd, req_reg_a, req_reg_b, req_imm);
      end
      bytes_outstanding = expected_bytes.size();
   end

endmodule

### test/x86_64_instruction_byte_encoder_tb.sv
// Testbench top for the x86-64 instruction byte encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module x86_64_instruction_byte_encoder_tb;
   import x86e_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int SETTLE_CYCLES   = 4;
   localparam int PHASE_REQUESTS  = 108;
   localparam logic [4:0] CMD_UNUSED_LO = 5'd25;
   localparam logic [4:0] CMD_UNUSED_HI = 5'd31;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_TOGGLE
   } ready_mode_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [63:0] csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   logic [4:0]  req_cmd;
   logic [3:0]  req_reg_a;
   logic [3:0]  req_reg_b;
   logic [63:0] req_imm;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_code_byte;
   logic        rsp_last_byte;
   logic        rsp_range_error;

   int             failures;
   int             bytes_outstanding;
   int             bytes_checked;
   int             range_errors;
   int             requests_sent;
   int             unused_sent;
   int             idle_cycles;
   int             burst_left;
   int             pattern_left;
   bit             hold_off;
   bit             no_gaps;
   ready_mode_type ready_mode;
   logic [63:0]    cur_base;

   x86_64_instruction_byte_encoder uut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_reg_a       (req_reg_a),
      .req_reg_b       (req_reg_b),
      .req_imm         (req_imm),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_byte   (rsp_code_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_range_error (rsp_range_error)
   );

   x86_64_instruction_byte_encoder_check code_check (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_reg_a         (req_reg_a),
      .req_reg_b         (req_reg_b),
      .req_imm           (req_imm),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_byte     (rsp_code_byte),
      .rsp_last_byte     (rsp_last_byte),
      .rsp_range_error   (rsp_range_error),
      .failures          (failures),
      .bytes_outstanding (bytes_outstanding),
      .bytes_checked     (bytes_checked),
      .range_errors      (range_errors)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("No handshake for %0d cycles, %0d bytes still pending.",
                     STALL_LIMIT, bytes_outstanding);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Response side: random ready patterns, plus a long hold-off when asked.
   initial begin
      rsp_ready = 1'b0;
      pattern_left = 0;
      ready_mode = READY_ALWAYS;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off = 0;
         end else begin
            if (pattern_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(8, 64);
            end
            pattern_left--;
            case (ready_mode)
               READY_ALWAYS: rsp_ready = 1'b1;
               READY_COIN:   rsp_ready = 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_ready = ($urandom_range(0, 3) == 0);
               default:      rsp_ready = pattern_left[1];
            endcase
         end
      end
   end

   task automatic send_request(input logic [4:0] c, input logic [3:0] a,
                               input logic [3:0] b, input logic [63:0] v);
      if (!no_gaps && burst_left == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 11)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid = 1'b1;
      req_cmd = c;
      req_reg_a = a;
      req_reg_b = b;
      req_imm = v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      if (c > CMD_CALL_PTR) unused_sent++;
   endtask

   // Stop offering, let every pending byte come out, then allow the pipeline to settle.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      wait (bytes_outstanding == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_code_base(input logic [63:0] v);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = v;
      cur_base = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_request();
      logic [4:0]  c;
      logic [63:0] v;
      logic [63:0] delta;
      if ($urandom_range(0, 39) == 0) c = 5'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else c = 5'($urandom_range(CMD_CALL_REG, CMD_CALL_PTR));
      case ($urandom_range(0, 4))
         0: v = 64'($urandom_range(0, 255));
         1: v = '1;
         2: v = {32'hffff_ffff, $urandom};
         default: v = {$urandom, $urandom};
      endcase
      // Aim most calls near the code buffer or near the edges of the rel32 reach.
      if (c == CMD_CALL_REL) begin
         case ($urandom_range(0, 3))
            0: begin
               delta = 64'($urandom_range(0, 2097152));
               v = cur_base + delta - 64'd1048576;
            end
            1: begin
               delta = 64'($urandom_range(0, 8191));
               v = cur_base + 64'h0000_0000_8000_0000 + delta;
            end
            2: begin
               delta = 64'($urandom_range(0, 8191));
               v = cur_base - 64'h0000_0000_8000_0000 + delta;
            end
            default: ;
         endcase
      end
      send_request(c, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), v);
   endtask

   initial begin
      logic [63:0] phase_base[4];
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_cmd = CMD_CALL_REG;
      req_reg_a = '0;
      req_reg_b = '0;
      req_imm = '0;
      requests_sent = 0;
      unused_sent = 0;
      idle_cycles = 0;
      burst_left = 0;
      hold_off = 0;
      no_gaps = 0;
      cur_base = '0;
      phase_base[0] = '0;
      phase_base[1] = '1;
      phase_base[2] = 64'h7fff_ffff_ffff_ff00;
      phase_base[3] = {$urandom, $urandom};
      repeat (10) @(negedge clock);
      reset = 1'b0;

      write_code_base(64'h0000_0000_0040_0000);
      // Starting from an empty code buffer, these calls sit on and just past the edges of the rel32 reach.
      send_request(CMD_CALL_REL, 4'd0, 4'd0, cur_base + 64'd5 + 64'h7fff_ffff);
      send_request(CMD_CALL_REL, 4'd0, 4'd0, cur_base + 64'd10 + 64'h8000_0000);
      send_request(CMD_CALL_REL, 4'd0, 4'd0, cur_base + 64'd10 - 64'h8000_0000);
      send_request(CMD_CALL_REL, 4'd0, 4'd0, cur_base + 64'd15 - 64'h8000_0001);
      send_request(CMD_CALL_REG, 4'd13, 4'd0, 64'd0);
      send_request(CMD_MOV16IMM, 4'd12, 4'd0, '1);
      send_request(CMD_MOV32IMM, 4'd4, 4'd0, 64'h0000_0000_8000_0000);
      send_request(CMD_SAL, 4'd15, 4'd0, 64'h3f);
      send_request(CMD_XOR, 4'd8, 4'd15, 64'd0);
      send_request(CMD_OR, 4'd0, 4'd0, 64'd0);
      send_request(CMD_RET, 4'd0, 4'd0, 64'd0);
      send_request(CMD_MOV64IMM, 4'd11, 4'd0, 64'h8877_6655_4433_2211);
      send_request(CMD_MOVL_IMEM, 4'd4, 4'd0, 64'h1234_5678);
      send_request(CMD_MOVL_RMEM, 4'd15, 4'd13, 64'd0);
      send_request(CMD_MOVQ_RR, 4'd9, 4'd7, 64'd0);
      send_request(CMD_MOVL_LOAD, 4'd12, 4'd3, 64'd0);
      send_request(CMD_ADD_EAX, 4'd0, 4'd0, 64'hffff_ffff_0000_0001);
      send_request(CMD_MOVL_RR, 4'd5, 4'd4, 64'd0);
      send_request(CMD_PUSH, 4'd0, 4'd0, 64'd0);
      send_request(CMD_POP, 4'd14, 4'd0, 64'd0);
      send_request(CMD_AND_RAX, 4'd0, 4'd0, '1);
      send_request(CMD_CMP_IMM32, 4'd10, 4'd0, 64'h7fff_ffff);
      send_request(CMD_XOR_RAX, 4'd0, 4'd0, 64'd0);
      send_request(CMD_NOT, 4'd3, 4'd0, 64'd0);
      send_request(CMD_MOVSX, 4'd5, 4'd8, 64'd0);
      send_request(CMD_CMPL_IMM8, 4'd2, 4'd0, 64'h80);
      send_request(CMD_JZ, 4'd0, 4'd0, 64'hfe);
      send_request(CMD_CALL_PTR, 4'd0, 4'd0, 64'h0123_4567_89ab_cdef);
      send_request(CMD_UNUSED_HI, 4'd15, 4'd15, '1);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_code_base(phase_base[ph]);
         no_gaps = (ph == 2);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            // Starve the response side mid-phase so the encoder backs up into its input.
            if (ph == 1 && n == 40) hold_off = 1;
            random_request();
         end
         drain();
      end

      $display("Covered %0d requests (%0d with unused selectors), %0d code bytes checked,",
               requests_sent, unused_sent, bytes_checked);
      $display("%0d call range errors, across five code_base settings including both extremes.",
               range_errors);
      if (failures == 0 && bytes_outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### sim.f
rtl/x86e_pkg.sv
rtl/x86e_encoder.sv
rtl/x86e_serializer.sv
rtl/x86_64_instruction_byte_encoder.sv
test/x86_64_instruction_byte_encoder_check.sv
test/x86_64_instruction_byte_encoder_tb.sv
